>>> sv/swl_pkg.sv
// Package for the sorted word lookup block: result status codes, sequencer
// states, control structs and fixed field widths. Depends on nothing.
package swl_pkg;

    localparam int WORD_W    = 64;
    localparam int LEN_W     = 4;
    localparam int CNT_W     = 11;
    localparam int MIN_CHARS = 4;

    typedef enum logic [2:0] {
        ST_LOADED  = 3'd0,
        ST_FULL    = 3'd1,
        ST_NEW     = 3'd2,
        ST_AGAIN   = 3'd3,
        ST_INVALID = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_OUT
    } state_t;

    typedef struct packed {
        logic init;
        logic step;
    } search_ctrl_t;

    typedef struct packed {
        logic hit;
        logic exhausted;
    } search_stat_t;

    typedef struct packed {
        logic load;
        logic hit;
    } stats_upd_t;

endpackage

>>> sv/swl_table.sv
// Word table memory: one write port and one registered read port, each
// entry a found mark above a 64-bit packed word. Depends on swl_pkg.
module swl_table #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [swl_pkg::WORD_W:0]  wr_data,
    input  logic [AW-1:0]             rd_addr,
    output logic [swl_pkg::WORD_W:0]  rd_data
);
    import swl_pkg::*;

    logic [WORD_W:0] mem [DEPTH];
    logic [WORD_W:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/swl_search.sv
// Binary search step unit: holds the search bounds and the shared 64-bit
// comparator that is used once per probe. Depends on swl_pkg.
module swl_search #(
    parameter int CW = 11,
    parameter int AW = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  swl_pkg::search_ctrl_t       ctrl,
    input  logic [CW-1:0]               init_hi,
    input  logic [swl_pkg::WORD_W-1:0]  probe,
    input  logic [swl_pkg::WORD_W-1:0]  key,
    output logic [AW-1:0]               addr,
    output swl_pkg::search_stat_t       stat
);
    import swl_pkg::*;

    // The live range is lo_reg up to but excluding hi1_reg.
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi1_reg, hi1_next;
    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    logic          probe_gt;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi1_reg} - (CW+1)'(1);
    assign mid      = mid_sum[CW:1];
    assign addr     = mid[AW-1:0];
    assign probe_gt = probe > key;
    assign stat.hit = probe == key;

    always_comb begin
        lo_next  = lo_reg;
        hi1_next = hi1_reg;
        if (ctrl.init) begin
            lo_next  = '0;
            hi1_next = init_hi;
        end else if (ctrl.step) begin
            if (probe_gt) begin
                hi1_next = mid;
            end else begin
                lo_next = mid + CW'(1);
            end
        end
    end

    assign stat.exhausted = !(lo_next < hi1_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg  <= '0;
            hi1_reg <= '0;
        end else begin
            lo_reg  <= lo_next;
            hi1_reg <= hi1_next;
        end
    end

`ifndef ASSERT_OFF
    a_range_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.step && !ctrl.init && !stat.hit && !stat.exhausted) |=> (lo_reg < hi1_reg))
        else $error("search range empty while probing continues");
`endif

endmodule

>>> sv/swl_stats.sv
// Running counters: loaded entries, found entries, and both per word length.
// Depends on swl_pkg.
module swl_stats #(
    parameter int CW    = 11,
    parameter int NSLOT = 5,
    parameter int SW    = 3
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  swl_pkg::stats_upd_t   upd,
    input  logic [SW-1:0]         slot,
    output logic [CW-1:0]         entry_count,
    output logic [CW-1:0]         found_count,
    output logic [CW-1:0]         total_sel,
    output logic [CW-1:0]         found_sel
);
    import swl_pkg::*;

    logic [CW-1:0] entry_count_reg;
    logic [CW-1:0] found_count_reg;
    logic [CW-1:0] total_reg [NSLOT];
    logic [CW-1:0] found_reg [NSLOT];
    logic          slot_ok;

    assign slot_ok = {1'b0, slot} < (SW+1)'(NSLOT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            found_count_reg <= '0;
            for (int i = 0; i < NSLOT; i++) begin
                total_reg[i] <= '0;
                found_reg[i] <= '0;
            end
        end else begin
            if (upd.load && slot_ok) begin
                entry_count_reg <= entry_count_reg + CW'(1);
                total_reg[slot] <= total_reg[slot] + CW'(1);
            end
            if (upd.hit && slot_ok) begin
                found_count_reg <= found_count_reg + CW'(1);
                found_reg[slot] <= found_reg[slot] + CW'(1);
            end
        end
    end

    assign entry_count = entry_count_reg;
    assign found_count = found_count_reg;
    assign total_sel   = slot_ok ? total_reg[slot] : '0;
    assign found_sel   = slot_ok ? found_reg[slot] : '0;

`ifndef ASSERT_OFF
    a_found_le_entries: assert property (@(posedge aclk) disable iff (!aresetn)
        found_count_reg <= entry_count_reg)
        else $error("more words found than loaded");
`endif

endmodule

>>> sv/sorted_word_lookup_with_marks_top.sv
// Top level of the sorted word lookup block: handshakes, sequencer and
// result register. Depends on swl_pkg, swl_table, swl_search and swl_stats.

// A load transaction appends a packed word at the next free table entry.
// A query transaction binary-searches the loaded entries; each probe passes
// through S_PROBE for the registered read of the single table port and
// S_CMP for the shared compare, with at most ceil(log2(n+1)) probes for n
// loaded words. A transaction with a length outside 4..MAX_CHARS, or a
// query on an empty table, goes straight to S_OUT with no table read. The
// block takes one transaction at a time; s_tready is high only while it
// is idle. A result held in the output register does not hold up the next
// transaction, but that one's own result waits in S_OUT until the register
// is free. Each load clears the found mark of the entry it writes, so no
// clearing pass runs after reset. Words must be loaded in ascending order
// for the search to be meaningful. Counters on the result are given modulo
// 2^11.
module sorted_word_lookup_with_marks_top #(
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_CHARS   = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel. s_tdata: word [63:0], word_len [67:64], zero pad.
    // s_tuser: action (0 load, 1 query).
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        s_tuser,
    // Result channel. m_tdata: status [2:0], found_total [13:3],
    // word_total [24:14], found_of_length [35:25],
    // remaining_of_length [46:36], all_found [47].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata
);
    import swl_pkg::*;

    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int NSLOT = MAX_CHARS - MIN_CHARS + 1;
    localparam int SW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;

    state_t state_reg, state_next;

    // Fields of the incoming transaction.
    logic [WORD_W-1:0] in_word;
    logic [LEN_W-1:0]  in_len;
    logic              in_query;
    logic              in_accept;
    logic              in_len_ok;
    logic [SW-1:0]     in_slot;

    assign in_word   = s_tdata[63:0];
    assign in_len    = s_tdata[67:64];
    assign in_query  = s_tuser;
    assign in_accept = s_tvalid && s_tready;
    assign in_len_ok = (in_len >= LEN_W'(MIN_CHARS)) && (in_len <= LEN_W'(MAX_CHARS));
    assign in_slot   = SW'(in_len - LEN_W'(MIN_CHARS));

    // Held copy of the transaction being worked on.
    logic [WORD_W-1:0] key_reg;
    logic [SW-1:0]     slot_reg;
    status_t           status_reg, status_next;
    logic              status_we;

    // Table, search and counter connections.
    logic              tbl_we;
    logic              tbl_mark;
    logic [AW-1:0]     tbl_waddr;
    logic [WORD_W:0]   tbl_wdata;
    logic [AW-1:0]     tbl_raddr;
    logic [WORD_W:0]   tbl_rdata;
    search_ctrl_t      srch_ctrl;
    search_stat_t      srch_stat;
    stats_upd_t        upd;
    logic [SW-1:0]     stat_slot;
    logic [CW-1:0]     entry_count;
    logic [CW-1:0]     found_count;
    logic [CW-1:0]     total_sel;
    logic [CW-1:0]     found_sel;
    logic              table_full;
    logic              table_empty;

    assign table_full  = entry_count == CW'(TABLE_DEPTH);
    assign table_empty = entry_count == '0;
    assign stat_slot   = (state_reg == S_IDLE) ? in_slot : slot_reg;

    // A load writes a cleared mark at the next free entry; a new hit sets the
    // mark of the entry just probed.
    assign tbl_waddr = tbl_mark ? tbl_raddr : entry_count[AW-1:0];
    assign tbl_wdata = tbl_mark ? {1'b1, key_reg} : {1'b0, in_word};

    // Result register.
    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;
    logic        out_load;
    logic [CW-1:0] remaining;
    logic          per_len_ok;

    assign remaining  = (total_sel > found_sel) ? (total_sel - found_sel) : '0;
    assign per_len_ok = status_reg != ST_INVALID;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    if (in_len_ok && in_query && !table_empty) begin
                        state_next = S_PROBE;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_PROBE: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                if (srch_stat.hit || srch_stat.exhausted) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_PROBE;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready    = 1'b0;
        tbl_we      = 1'b0;
        tbl_mark    = 1'b0;
        srch_ctrl   = '0;
        upd         = '0;
        status_we   = 1'b0;
        status_next = ST_INVALID;
        out_load    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (in_accept) begin
                    status_we = 1'b1;
                    if (!in_len_ok) begin
                        status_next = ST_INVALID;
                    end else if (!in_query) begin
                        if (table_full) begin
                            status_next = ST_FULL;
                        end else begin
                            status_next = ST_LOADED;
                            tbl_we      = 1'b1;
                            upd.load    = 1'b1;
                        end
                    end else if (table_empty) begin
                        status_next = ST_INVALID;
                    end else begin
                        srch_ctrl.init = 1'b1;
                    end
                end
            end
            S_PROBE: begin
                // The read address is presented here; data arrives next cycle.
            end
            S_CMP: begin
                srch_ctrl.step = 1'b1;
                if (srch_stat.hit) begin
                    status_we = 1'b1;
                    if (tbl_rdata[WORD_W]) begin
                        status_next = ST_AGAIN;
                    end else begin
                        status_next = ST_NEW;
                        tbl_we      = 1'b1;
                        tbl_mark    = 1'b1;
                        upd.hit     = 1'b1;
                    end
                end else if (srch_stat.exhausted) begin
                    status_we   = 1'b1;
                    status_next = ST_INVALID;
                end
            end
            S_OUT: begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            key_reg  <= in_word;
            slot_reg <= in_slot;
        end
        if (status_we) begin
            status_reg <= status_next;
        end
        if (out_load) begin
            m_tdata_reg <= {
                found_count == entry_count,
                per_len_ok ? CNT_W'(remaining) : CNT_W'(0),
                per_len_ok ? CNT_W'(found_sel) : CNT_W'(0),
                CNT_W'(entry_count),
                CNT_W'(found_count),
                status_reg
            };
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    swl_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_we),
        .wr_addr (tbl_waddr),
        .wr_data (tbl_wdata),
        .rd_addr (tbl_raddr),
        .rd_data (tbl_rdata)
    );

    swl_search #(
        .CW (CW),
        .AW (AW)
    ) u_search (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (srch_ctrl),
        .init_hi (entry_count),
        .probe   (tbl_rdata[WORD_W-1:0]),
        .key     (key_reg),
        .addr    (tbl_raddr),
        .stat    (srch_stat)
    );

    swl_stats #(
        .CW    (CW),
        .NSLOT (NSLOT),
        .SW    (SW)
    ) u_stats (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .upd         (upd),
        .slot        (stat_slot),
        .entry_count (entry_count),
        .found_count (found_count),
        .total_sel   (total_sel),
        .found_sel   (found_sel)
    );

`ifndef ASSERT_OFF
    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_we |-> (state_reg == S_IDLE || state_reg == S_CMP))
        else $error("table written outside load or hit");
    a_load_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && !in_query && in_len_ok && !table_full)
        |=> (entry_count == $past(entry_count) + CW'(1)))
        else $error("accepted load did not advance the entry count");
    a_probe_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PROBE) |-> !table_empty)
        else $error("probing an empty table");
`endif

endmodule

>>> sim/sorted_word_lookup_with_marks_top_tb.sv
// Self-checking testbench for the sorted word lookup block: loads a sorted
// dictionary, queries it under random back-pressure and checks every result.
// Depends on swl_pkg and sorted_word_lookup_with_marks_top.
`timescale 1ns / 100ps

module sorted_word_lookup_with_marks_top_tb;

    import swl_pkg::*;

    localparam int  CLK_PERIOD     = 2;
    localparam int  RESET_CYCLES   = 11;
    localparam int  TABLE_DEPTH    = 1024;
    localparam int  MAX_CHARS      = 8;
    localparam int  LEN_SLOTS      = MAX_CHARS - MIN_CHARS + 1;
    // Allow for a full-table query plus a margin.
    localparam int  DRAIN_CYCLES   = 60;
    // Longest legal silence is the receiver hold-off plus a long gap on each
    // side and one slow search, so this is several times over.
    localparam int  WATCHDOG_LIMIT = 3000;
    localparam int  HOLD_AT        = 300;
    localparam int  HOLD_CYCLES    = 400;

    // The dictionary is built from six directed words, a run of lower-case
    // words, a run of words with the top bit set and the all-ones word.
    localparam int  DIRECTED_LOADS = 6;
    localparam int  HIGH_WORDS     = 200;
    localparam int  ASCII_WORDS    = TABLE_DEPTH - DIRECTED_LOADS - HIGH_WORDS - 1;
    localparam logic [WORD_W-1:0] HIGH_BASE = 64'h8000_0000_0000_0000;
    localparam logic [WORD_W-1:0] HIGH_STEP = 64'h00A0_0000_0000_0000;
    localparam logic [WORD_W-1:0] HIGH_MASK = 64'h007F_FFFF_FFFF_FFFF;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic              action;
        logic [WORD_W-1:0] word;
        logic [LEN_W-1:0]  len;
    } lookup_req_t;

    typedef struct packed {
        status_t          status;
        logic [CNT_W-1:0] found_total;
        logic [CNT_W-1:0] word_total;
        logic [CNT_W-1:0] found_of_len;
        logic [CNT_W-1:0] remaining_of_len;
        logic             all_found;
    } lookup_reply_t;

    // Every input of the block starts at a known value.
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    // Transactions waiting to be offered, and replies predicted but not yet seen.
    lookup_req_t   word_requests[$];
    lookup_reply_t expected_replies[$];

    // Words queued for loading, in table order, so that queries can aim at them.
    logic [WORD_W-1:0] staged_words[$];
    logic [LEN_W-1:0]  staged_lens[$];

    // Private copy of the dictionary state, updated as transactions are accepted.
    logic [WORD_W-1:0] dict_words [TABLE_DEPTH];
    bit                dict_marks [TABLE_DEPTH];
    int unsigned       dict_count = 0;
    int unsigned       hit_count  = 0;
    int unsigned       len_loaded [LEN_SLOTS];
    int unsigned       len_hit    [LEN_SLOTS];

    int            error_count  = 0;
    int            results_seen = 0;
    int            idle_cycles  = 0;
    logic          in_taken     = 1'b0;

    lookup_req_t   drv_req;
    int            send_gap   = 0;
    bit            send_quiet = 1'b0;
    int            stall_left = 0;
    int            hold_left  = 0;
    bit            hold_done  = 1'b0;
    bit            recv_quiet = 1'b0;
    lookup_req_t   seen_req;
    lookup_reply_t seen_reply;
    lookup_reply_t want_reply;

    sorted_word_lookup_with_marks_top #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_CHARS   (MAX_CHARS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // word [63:0], word_len [67:64], zero pad [71:68]
        .s_tuser  (s_tuser),   // action
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // status, found_total, word_total, found_of_length,
                               // remaining_of_length, all_found
    );

    always #(CLK_PERIOD / 2.0) aclk = ~aclk;

    // Works out the reply to one accepted transaction and moves the private
    // dictionary state on. Out-of-order tables are searched by the same fixed
    // probe sequence as the hardware, so whatever it finds is what we expect.
    function automatic lookup_reply_t predict_lookup(lookup_req_t rq);
        lookup_reply_t rp;
        bit            len_ok;
        bit            hit;
        int            slot;
        int            lo;
        int            hi;
        int            mid;
        int            pos;
        int unsigned   f;
        int unsigned   t;
        len_ok = (rq.len >= MIN_CHARS) && (rq.len <= MAX_CHARS);
        slot   = int'(rq.len) - MIN_CHARS;
        hit    = 1'b0;
        pos    = 0;
        if (!len_ok) begin
            rp.status = ST_INVALID;
        end else if (rq.action == ACT_LOAD) begin
            if (dict_count >= TABLE_DEPTH) begin
                rp.status = ST_FULL;
            end else begin
                dict_words[dict_count] = rq.word;
                dict_marks[dict_count] = 1'b0;
                dict_count++;
                len_loaded[slot]++;
                rp.status = ST_LOADED;
            end
        end else begin
            lo = 0;
            hi = int'(dict_count) - 1;
            while (lo <= hi && !hit) begin
                mid = (lo + hi) / 2;
                if (dict_words[mid] == rq.word) begin
                    hit = 1'b1;
                    pos = mid;
                end else if (dict_words[mid] > rq.word) begin
                    hi = mid - 1;
                end else begin
                    lo = mid + 1;
                end
            end
            if (!hit) begin
                rp.status = ST_INVALID;
            end else if (dict_marks[pos]) begin
                rp.status = ST_AGAIN;
            end else begin
                dict_marks[pos] = 1'b1;
                hit_count++;
                len_hit[slot]++;
                rp.status = ST_NEW;
            end
        end
        rp.found_total = CNT_W'(hit_count);
        rp.word_total  = CNT_W'(dict_count);
        if (len_ok && rp.status != ST_INVALID) begin
            // The length comes from the transaction, not from the word, so the
            // found count for a length can overtake its total; clamp at zero.
            f = len_hit[slot];
            t = len_loaded[slot];
            rp.found_of_len     = CNT_W'(f);
            rp.remaining_of_len = CNT_W'(t > f ? t - f : 0);
        end else begin
            rp.found_of_len     = '0;
            rp.remaining_of_len = '0;
        end
        rp.all_found = (hit_count == dict_count);
        return rp;
    endfunction

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [WORD_W-1:0] text_word(string s);
        logic [WORD_W-1:0] w;
        w = '0;
        for (int i = 0; i < s.len(); i++)
            w[WORD_W-1-8*i -: 8] = s[i];
        return w;
    endfunction

    // Lower-case word whose first three letters follow idx, so that rising idx
    // gives rising words; the tail is random letters up to nchars.
    function automatic logic [WORD_W-1:0] ascii_word(int idx, int nchars);
        logic [WORD_W-1:0] w;
        w         = '0;
        w[63:56]  = 8'h66 + 8'(idx / 676);          // from 'f' upwards
        w[55:48]  = 8'h61 + 8'((idx / 26) % 26);
        w[47:40]  = 8'h61 + 8'(idx % 26);
        for (int i = 3; i < nchars; i++)
            w[WORD_W-1-8*i -: 8] = 8'h61 + 8'($urandom_range(0, 25));
        return w;
    endfunction

    function automatic logic [LEN_W-1:0] bad_len();
        if ($urandom_range(0, 1))
            return LEN_W'($urandom_range(0, MIN_CHARS - 1));
        return LEN_W'($urandom_range(MAX_CHARS + 1, 15));
    endfunction

    function automatic logic [LEN_W-1:0] good_len();
        return LEN_W'($urandom_range(MIN_CHARS, MAX_CHARS));
    endfunction

    task automatic add_item(logic action, logic [WORD_W-1:0] word, logic [LEN_W-1:0] len);
        lookup_req_t rq;
        rq.action = action;
        rq.word   = word;
        rq.len    = len;
        word_requests.push_back(rq);
        if (action == ACT_LOAD && len >= MIN_CHARS && len <= MAX_CHARS
                && staged_words.size() < TABLE_DEPTH) begin
            staged_words.push_back(word);
            staged_lens.push_back(len);
        end
    endtask

    // A query that mostly hits a word already queued for loading, favouring
    // the most recent ones so that both first and repeated hits are common.
    task automatic add_random_query();
        int                n;
        int                r;
        int                idx;
        logic [WORD_W-1:0] w;
        logic [LEN_W-1:0]  wl;
        n = staged_words.size();
        r = $urandom_range(0, 99);
        if (n > 0 && r < 70) begin
            if (r < 20)
                idx = n - 1 - $urandom_range(0, n > 8 ? 7 : n - 1);
            else
                idx = $urandom_range(0, n - 1);
            w  = staged_words[idx];
            wl = staged_lens[idx];
            if ($urandom_range(0, 9) == 0)
                wl = good_len();
            if (r >= 64)
                wl = bad_len();
        end else if (r < 85) begin
            w  = ascii_word($urandom_range(0, ASCII_WORDS - 1), $urandom_range(4, 8));
            wl = good_len();
        end else begin
            w  = {$urandom, $urandom};
            wl = (r < 95) ? good_len() : bad_len();
        end
        add_item(ACT_QUERY, w, wl);
    endtask

    task automatic check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    // Sender: offers the next queued transaction once the current one has been
    // taken, with a random gap between transactions.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (word_requests.size() > 0) begin
                drv_req = word_requests.pop_front();
                s_tdata  <= {4'b0, drv_req.len, drv_req.word};
                s_tuser  <= drv_req.action;
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 199) == 0)
                    send_quiet = !send_quiet;
                send_gap = pick_gap(send_quiet);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off early in the run while
    // the sender keeps offering, so that the block backs up and stalls its input.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 199) == 0)
                recv_quiet = !recv_quiet;
            stall_left = pick_gap(recv_quiet);
        end
    end

    // Monitor: predicts on every accepted input transaction and checks every
    // accepted result against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_taken    <= 1'b0;
            idle_cycles <= 0;
        end else begin
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                seen_req.action = s_tuser;
                seen_req.word   = s_tdata[WORD_W-1:0];
                seen_req.len    = s_tdata[WORD_W +: LEN_W];
                expected_replies.push_back(predict_lookup(seen_req));
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                seen_reply.status           = status_t'(m_tdata[2:0]);
                seen_reply.found_total      = m_tdata[13:3];
                seen_reply.word_total       = m_tdata[24:14];
                seen_reply.found_of_len     = m_tdata[35:25];
                seen_reply.remaining_of_len = m_tdata[46:36];
                seen_reply.all_found        = m_tdata[47];
                if (expected_replies.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, got m_tdata %h",
                             $time, m_tdata);
                    error_count++;
                end else begin
                    want_reply = expected_replies.pop_front();
                    check_field("status", want_reply.status, seen_reply.status);
                    check_field("found_total", want_reply.found_total,
                                seen_reply.found_total);
                    check_field("word_total", want_reply.word_total,
                                seen_reply.word_total);
                    check_field("found_of_length", want_reply.found_of_len,
                                seen_reply.found_of_len);
                    check_field("remaining_of_length", want_reply.remaining_of_len,
                                seen_reply.remaining_of_len);
                    check_field("all_found", want_reply.all_found, seen_reply.all_found);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog: a long stretch with no transaction on either side means a hang.
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge aclk);
        $display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("sorted_word_lookup_with_marks_top_tb: done, errors");
        $finish;
    end

    initial begin
        logic [WORD_W-1:0] w;
        logic [LEN_W-1:0]  wl;

        // Directed opening: a query on the empty table, loads with lengths out
        // of range at both ends, the zero word, one word of each valid length,
        // first and repeated hits, a length that disagrees with its word (so
        // that the found count for length 8 overtakes its total), misses above
        // the table and a bad length on a word that is present.
        add_item(ACT_QUERY, text_word("abcd"), 4'd4);
        add_item(ACT_LOAD,  text_word("xyz"), 4'd3);
        add_item(ACT_LOAD,  '0, 4'd0);
        add_item(ACT_LOAD,  {$urandom, $urandom}, 4'd9);
        add_item(ACT_LOAD,  {$urandom, $urandom}, 4'd15);
        add_item(ACT_LOAD,  '0, 4'd4);
        add_item(ACT_LOAD,  text_word("AAAA"), 4'd4);
        add_item(ACT_LOAD,  text_word("BBBBB"), 4'd5);
        add_item(ACT_LOAD,  text_word("CCCCCC"), 4'd6);
        add_item(ACT_LOAD,  text_word("DDDDDDD"), 4'd7);
        add_item(ACT_LOAD,  text_word("EEEEEEEE"), 4'd8);
        add_item(ACT_QUERY, '0, 4'd4);
        add_item(ACT_QUERY, '0, 4'd4);
        add_item(ACT_QUERY, '0, 4'd0);
        add_item(ACT_QUERY, text_word("AAAA"), 4'd8);
        add_item(ACT_QUERY, text_word("EEEEEEEE"), 4'd8);
        add_item(ACT_QUERY, text_word("BBBBB"), 4'd5);
        add_item(ACT_QUERY, text_word("CCCCCC"), 4'd6);
        add_item(ACT_QUERY, text_word("DDDDDDD"), 4'd7);
        add_item(ACT_QUERY, text_word("ZZZZ"), 4'd4);
        add_item(ACT_QUERY, '1, 4'd8);
        add_item(ACT_QUERY, text_word("AAAB"), 4'd12);

        // Random part: fill the table in ascending order, with queries and
        // some bad-length loads scattered between the loads.
        for (int k = 0; k < ASCII_WORDS + HIGH_WORDS + 1; k++) begin
            if (k < ASCII_WORDS) begin
                wl = good_len();
                w  = ascii_word(k, wl);
            end else if (k < ASCII_WORDS + HIGH_WORDS) begin
                wl = good_len();
                w  = HIGH_BASE + WORD_W'(k - ASCII_WORDS) * HIGH_STEP
                     + ({$urandom, $urandom} & HIGH_MASK);
            end else begin
                wl = 4'd8;
                w  = '1;
            end
            if ($urandom_range(0, 19) == 0)
                wl = good_len();
            if ($urandom_range(0, 19) == 0)
                add_item(ACT_LOAD, {$urandom, $urandom}, bad_len());
            while ($urandom_range(0, 99) < 22)
                add_random_query();
            add_item(ACT_LOAD, w, wl);
        end

        // The table is now full: further loads are dropped.
        add_item(ACT_LOAD, {$urandom, $urandom}, 4'd4);
        add_item(ACT_LOAD, {$urandom, $urandom}, 4'd6);
        add_item(ACT_LOAD, {$urandom, $urandom}, 4'd8);
        add_item(ACT_LOAD, {$urandom, $urandom}, bad_len());
        add_item(ACT_QUERY, '0, 4'd4);
        add_item(ACT_QUERY, '1, 4'd8);
        repeat (80)
            add_random_query();

        repeat (RESET_CYCLES)
            @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (word_requests.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (expected_replies.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES)
            @(posedge aclk);

        if (error_count == 0)
            $display("sorted_word_lookup_with_marks_top_tb: done, clean");
        else
            $display("sorted_word_lookup_with_marks_top_tb: done, errors");
        $finish;
    end

endmodule
